// ----- hdl/i64da_pkg.sv -----
// ----------------------------------------------------------------------------
// i64da_pkg
// Shared types and constants for the 64-bit integer to decimal text converter.
// ----------------------------------------------------------------------------
package i64da_pkg;

	// magnitude width and number of decimal digit cells (2^63 has 19 digits)
	localparam int MAG_W      = 64;
	localparam int NUM_DIGITS = 19;
	localparam int CNT_W      = $clog2(MAG_W);
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);

	// ascii codes on the 6-bit character port
	localparam logic [5:0] CHAR_MINUS = 6'd45;
	localparam logic [5:0] CHAR_ZERO  = 6'd48;

	// bcd digit limits used by the shift-and-add-3 step
	localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
	localparam logic [3:0] DIGIT_ADJ_ADD = 4'd3;
	localparam logic [3:0] DIGIT_MAX     = 4'd9;

	// operation applied to every cell of the digit chain together
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_CONV,
		CELL_SHIFT
	} cell_op_t;

	// control sent from the sequencer to the digit chain
	typedef struct packed {
		cell_op_t op;
		logic     serial_bit;
	} chain_ctl_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage

// ----- hdl/i64da_cell.sv -----
// ----------------------------------------------------------------------------
// i64da_cell
// One bcd digit of the conversion chain: shift-and-add-3 step during
// conversion, plain digit shift toward the top during output.
// ----------------------------------------------------------------------------
module i64da_cell
	import i64da_pkg::*;
(
	input  logic       clk,
	input  cell_op_t   op,
	input  logic [3:0] digit_in,
	input  logic       bit_in,
	output logic [3:0] digit,
	output logic       bit_out
);

	logic [3:0] digit_q;
	logic [3:0] adj;
	logic [3:0] digit_d;

	// add 3 when the digit would overflow after doubling
	assign adj = (digit_q >= DIGIT_ADJ_MIN) ? (digit_q + DIGIT_ADJ_ADD) : digit_q;

	// next digit per chain operation
	always_comb begin
		case (op)
			CELL_CLEAR: digit_d = 4'd0;
			CELL_CONV:  digit_d = {adj[2:0], bit_in};
			CELL_SHIFT: digit_d = digit_in;
			CELL_HOLD:  digit_d = digit_q;
			default:    digit_d = digit_q;
		endcase
	end

	always_ff @(posedge clk) begin
		digit_q <= digit_d;
	end

	// carry into the next more significant digit
	assign bit_out = adj[3];
	assign digit   = digit_q;

endmodule

// ----- hdl/i64da_ctrl.sv -----
// ----------------------------------------------------------------------------
// i64da_ctrl
// Sequencer: takes the input value, feeds its magnitude bit by bit into the
// digit chain, drops leading zeros and drives the character output register.
// ----------------------------------------------------------------------------
module i64da_ctrl
	import i64da_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic signed [63:0] value,
	input  logic              value_valid,
	output logic              value_stall,
	output logic [5:0]        char_code,
	output logic              last,
	output logic              char_valid,
	input  logic              char_stall,
	input  logic [3:0]        top_digit,
	output chain_ctl_t        chain_ctl
);

	state_t             state_q, state_d;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [REM_W-1:0]   rem_q;
	logic [5:0]         char_q;
	logic               last_q;
	logic               out_valid_q;

	logic               in_xfer;
	logic               out_load;
	logic               conv_done;
	logic               skip_zero;
	logic               rem_one;
	logic [MAG_W-1:0]   value_mag;

	assign in_xfer   = value_valid && !value_stall;
	assign out_load  = !out_valid_q || !char_stall;
	assign conv_done = (cnt_q == CNT_W'(MAG_W - 1));
	assign rem_one   = (rem_q == REM_W'(1));
	assign skip_zero = (top_digit == 4'd0) && !rem_one;
	assign value_mag = value[63] ? (~MAG_W'(value) + MAG_W'(1)) : MAG_W'(value);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (value_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!skip_zero) state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (out_load) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load && rem_one) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs: input stall and chain operation
	always_comb begin
		value_stall          = 1'b1;
		chain_ctl.op         = CELL_HOLD;
		chain_ctl.serial_bit = mag_q[MAG_W-1];
		case (state_q)
			ST_IDLE: begin
				value_stall = 1'b0;
				if (value_valid) chain_ctl.op = CELL_CLEAR;
			end
			ST_CONV: chain_ctl.op = CELL_CONV;
			ST_SKIP: begin
				if (skip_zero) chain_ctl.op = CELL_SHIFT;
			end
			ST_EMIT: begin
				if (out_load) chain_ctl.op = CELL_SHIFT;
			end
			default: chain_ctl.op = CELL_HOLD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				cnt_q <= '0;
			end else if (state_q == ST_CONV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_CONV && conv_done) begin
				rem_q <= REM_W'(NUM_DIGITS);
			end else if ((state_q == ST_SKIP && skip_zero) ||
			             (state_q == ST_EMIT && out_load)) begin
				rem_q <= rem_q - REM_W'(1);
			end
			if ((state_q == ST_SIGN || state_q == ST_EMIT) && out_load) begin
				out_valid_q <= 1'b1;
			end else if (!char_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// magnitude shift register and output payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q <= value_mag;
			neg_q <= value[63];
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
		end
		if (state_q == ST_SIGN && out_load) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_load) begin
			char_q <= CHAR_ZERO + {2'b00, top_digit};
			last_q <= rem_one;
		end
	end

	assign char_code  = char_q;
	assign last       = last_q;
	assign char_valid = out_valid_q;

	// an accepted value starts conversion from bit count zero
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_CONV && cnt_q == '0))
		else $error("conversion did not start after input transfer");

	// the chain never holds a non-decimal digit at the top while skipping or emitting
	a_top_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> (top_digit <= DIGIT_MAX))
		else $error("top digit out of decimal range");

	// digits remain while emitting
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_SKIP) |-> (rem_q != '0))
		else $error("digit count underflow");

	// the sign is never the final character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN && out_load) |=> (char_q == CHAR_MINUS && !last_q && out_valid_q))
		else $error("minus sign loaded incorrectly");

endmodule

// ----- hdl/int64_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// Signed 64-bit integer to decimal ascii text, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel value/value_valid/value_stall carries one signed 64-bit
//    integer per transfer; output channel char_code/last/char_valid/char_stall
//    carries the text, most significant character first, last on the final one
//  - negative values start with a minus sign (45); zero gives a single '0'
//  - the magnitude is shifted one bit per cycle into a row of 19 bcd digit
//    cells (shift-and-add-3); leading zeros are then dropped one cell shift
//    per cycle
//  - the conversion row is the limit: one item is in work at a time, and a
//    new value is taken while the final character still waits in the output
//    register
//  - char_stall holds the output register and pauses the digit row while emitting
//  - reset clears the sequencer and the output valid; nothing is kept
//    between items
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii
	import i64da_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [63:0] value,
	input  logic               value_valid,
	output logic               value_stall,
	output logic [5:0]         char_code,
	output logic               last,
	output logic               char_valid,
	input  logic               char_stall
);

	chain_ctl_t chain_ctl;
	logic [3:0] digit [NUM_DIGITS];
	logic       carry [NUM_DIGITS];

	// sequencer and output register
	i64da_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.char_code   (char_code),
		.last        (last),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.top_digit   (digit[NUM_DIGITS-1]),
		.chain_ctl   (chain_ctl)
	);

	// row of bcd digit cells, least significant at index 0
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			i64da_cell u_cell (
				.clk      (clk),
				.op       (chain_ctl.op),
				.digit_in (4'd0),
				.bit_in   (chain_ctl.serial_bit),
				.digit    (digit[i]),
				.bit_out  (carry[i])
			);
		end else begin : g_rest
			i64da_cell u_cell (
				.clk      (clk),
				.op       (chain_ctl.op),
				.digit_in (digit[i-1]),
				.bit_in   (carry[i-1]),
				.digit    (digit[i]),
				.bit_out  (carry[i])
			);
		end
	end

endmodule
